[rtl/core/csvfs_pkg.sv]
// Package for the CSV field splitter: field store sizing, character codes,
// controller states and the command and status structs between the modules.
// Depends on nothing; every other file of the block imports it.
package csvfs_pkg;

   // Field store sizing.
   localparam int FIELD_BYTES = 64;
   localparam int ADDR_W      = $clog2(FIELD_BYTES);
   localparam int LEN_W       = $clog2(FIELD_BYTES + 1);

   // Character codes.
   localparam logic [7:0] QUOTE_CHAR  = 8'h22;
   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] TAB_CHAR    = 8'h09;
   localparam logic [7:0] CR_CHAR     = 8'h0D;

   // Parser mode within one field.
   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_UNQUOTED = 2'd1,
      MODE_QUOTED   = 2'd2
   } mode_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LONE,
      ST_EMPTY,
      ST_LO_RD,
      ST_LO_CHK,
      ST_HI_RD,
      ST_HI_CHK,
      ST_STRIP,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   // Which pointer addresses the field store read.
   typedef enum logic {
      RD_LO,
      RD_HI
   } rd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       lo_inc;
      logic       hi_dec;
      logic       strip;
      logic       set_fq;
      logic       set_lq;
      logic       load_byte;
      logic       load_empty;
      logic       empty_lone;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit_lone;
      logic do_flush;
      logic eor_empty;
      logic lo_lt_hi;
      logic rd_is_ws;
      logic emit_last;
      logic strip_empty;
      logic out_free;
   } status_type;

   // Whitespace test: space, or tab up to carriage return.
   function automatic logic is_space(input logic [7:0] c);
      return (c == SPACE_CHAR) || ((c >= TAB_CHAR) && (c <= CR_CHAR));
   endfunction

endpackage

[rtl/core/csv_field_splitter.sv]
// Top level of the CSV field splitter: joins the controller and datapath.
// Depends on csvfs_pkg, csvfs_ctrl and csvfs_datapath.
//
//   Channel  Dir  Carries                                                   Handshake
//   req_*    in   in_byte, end_of_record                                    tvalid & tready
//   rsp_*    out  out_byte, field_last, field_empty, record_last, truncated tvalid & tready
//   csr_*    in   delimiter_char                                            valid & ready
//
// Bytes that end no field are taken one per cycle, save one after a leading delimiter.
// At a field end the store is walked: leading, then trailing bytes are read and tested,
// the quotes checked, each kept byte read and loaded; an empty window loads an empty field.
// Reset is synchronous; it restores the ',' delimiter and clears the parser, not the store.
// A result waits in the output register while input goes on; a stalled rsp_tready holds
// emission, and with it input acceptance, until the pending field has been sent.
module csv_field_splitter (
   input  logic       clock,
   input  logic       reset,
   // in_byte [7:0]
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       req_tvalid,
   output logic       req_tready,
   // out_byte [7:0]
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   // field_empty [0], record_last [1], truncated [2]
   output logic [2:0] rsp_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // delimiter_char [7:0]
   input  logic [7:0] csr_data,
   input  logic       csr_valid,
   output logic       csr_ready
);
   import csvfs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The delimiter register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // Sequencing of acceptance, trimming and emission.
   csvfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Parser, field store and result register.
   csvfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[rtl/core/csvfs_ctrl.sv]
// Controller of the CSV field splitter: sequences item acceptance, the trim
// scans over the field store and the emission of each field.
// Depends on csvfs_pkg for the state enum and the command and status structs.
module csvfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output csvfs_pkg::cmd_type     cmd,
   input  csvfs_pkg::status_type  status
);
   import csvfs_pkg::*;

   state_type state_ff, state_in;
   logic      flush_pend_ff, flush_pend_in;

   // State and pending-flush registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flush_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flush_pend_ff <= flush_pend_in;
      end
   end

   // Next state.
   always_comb begin
      state_in      = state_ff;
      flush_pend_in = flush_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               flush_pend_in = status.do_flush;
               priority if (status.emit_lone) state_in = ST_LONE;
               else if (status.do_flush)      state_in = ST_LO_RD;
               else if (status.eor_empty)     state_in = ST_EMPTY;
               else                           state_in = ST_IDLE;
            end
         end
         ST_LONE: begin
            if (status.out_free) state_in = flush_pend_ff ? ST_LO_RD : ST_IDLE;
         end
         ST_EMPTY: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_LO_RD: begin
            state_in = status.lo_lt_hi ? ST_LO_CHK : ST_EMPTY;
         end
         ST_LO_CHK: begin
            state_in = status.rd_is_ws ? ST_LO_RD : ST_HI_RD;
         end
         ST_HI_RD: begin
            state_in = ST_HI_CHK;
         end
         ST_HI_CHK: begin
            state_in = status.rd_is_ws ? ST_HI_RD : ST_STRIP;
         end
         ST_STRIP: begin
            state_in = status.strip_empty ? ST_EMPTY : ST_EM_RD;
         end
         ST_EM_RD: begin
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (status.out_free) state_in = status.emit_last ? ST_IDLE : ST_EM_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.rd_sel = RD_LO;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LONE: begin
            cmd.load_empty = status.out_free;
            cmd.empty_lone = 1'b1;
         end
         ST_EMPTY: begin
            cmd.load_empty = status.out_free;
         end
         ST_LO_RD: begin
            cmd.rd_en = status.lo_lt_hi;
         end
         ST_LO_CHK: begin
            cmd.lo_inc = status.rd_is_ws;
            cmd.set_fq = !status.rd_is_ws;
         end
         ST_HI_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HI;
         end
         ST_HI_CHK: begin
            cmd.hi_dec = status.rd_is_ws;
            cmd.set_lq = !status.rd_is_ws;
         end
         ST_STRIP: begin
            cmd.strip = 1'b1;
         end
         ST_EM_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_EM_OUT: begin
            cmd.load_byte = status.out_free;
            cmd.lo_inc    = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/core/csvfs_datapath.sv]
// Datapath of the CSV field splitter: parser state, delimiter register,
// field store memory, trim pointers and the result register.
// Depends on csvfs_pkg for sizing, character codes and the command structs.
module csvfs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   csr_valid,
   input  logic [7:0]             csr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   output logic [2:0]             rsp_tuser,
   input  csvfs_pkg::cmd_type     cmd,
   output csvfs_pkg::status_type  status
);
   import csvfs_pkg::*;

   // Parser state.
   logic [7:0]       delim_ff, delim_in;
   mode_type         mode_ff, mode_in, mode_nx;
   logic             pend_ff, pend_in, pend_nx;
   logic [LEN_W-1:0] len_ff, len_in, len_nx;
   logic             ovf_ff, ovf_in, ovf_nx;
   logic             has_ff, has_in, has_nx;
   logic             eod_ff, eod_in, eod_nx;
   logic             lone_ff, lone_in, lone_nx;

   // Emission state.
   logic [LEN_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic             trunc_ff, trunc_in, rlast_ff, rlast_in;
   logic             fq_ff, fq_in, lq_ff, lq_in;

   // Field store.
   logic [7:0]       field_store [FIELD_BYTES];
   logic [7:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   // Result register.
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic             out_flast_ff, out_empty_ff, out_rlast_ff, out_trunc_ff;

   logic             dec_lone, dec_flush, dec_eor_empty, dec_push, unq_path;
   logic             is_quote, is_delim, store_full;
   logic [LEN_W-1:0] span, lo_p1, hi_m1;
   logic             strip_ok;

   assign is_quote   = (req_tdata == QUOTE_CHAR);
   assign is_delim   = (req_tdata == delim_ff);
   assign store_full = (len_ff == LEN_W'(FIELD_BYTES));

   // Parse decision for the offered item.
   always_comb begin
      mode_nx       = mode_ff;
      pend_nx       = pend_ff;
      len_nx        = len_ff;
      ovf_nx        = ovf_ff;
      has_nx        = has_ff;
      eod_nx        = eod_ff;
      lone_nx       = lone_ff;
      dec_lone      = 1'b0;
      dec_flush     = 1'b0;
      dec_eor_empty = 1'b0;
      dec_push      = 1'b0;
      unq_path      = 1'b0;
      if (req_tlast) begin
         if (has_ff) begin
            if (lone_ff || eod_ff) dec_eor_empty = 1'b1;
            else                   dec_flush     = 1'b1;
         end
         mode_nx = MODE_START;
         pend_nx = 1'b0;
         len_nx  = '0;
         ovf_nx  = 1'b0;
         has_nx  = 1'b0;
         eod_nx  = 1'b0;
         lone_nx = 1'b0;
      end else begin
         has_nx   = 1'b1;
         dec_lone = lone_ff;
         lone_nx  = 1'b0;
         eod_nx   = 1'b0;
         unique case (mode_ff)
            MODE_START: begin
               if (is_quote) begin
                  mode_nx = MODE_QUOTED;
               end else if (is_delim) begin
                  eod_nx = 1'b1;
                  if (!has_ff) lone_nx   = 1'b1;
                  else         dec_flush = 1'b1;
               end else begin
                  dec_push = 1'b1;
                  mode_nx  = MODE_UNQUOTED;
               end
            end
            MODE_QUOTED: begin
               if (pend_ff) begin
                  pend_nx = 1'b0;
                  if (is_quote) dec_push = 1'b1;
                  else          unq_path = 1'b1;
               end else if (is_quote) begin
                  pend_nx = 1'b1;
               end else begin
                  dec_push = 1'b1;
               end
            end
            MODE_UNQUOTED: unq_path = 1'b1;
            default:       unq_path = 1'b1;
         endcase
         // Unquoted handling, also reached after a quoted section closes.
         if (unq_path) begin
            mode_nx = MODE_UNQUOTED;
            if (is_delim) begin
               dec_flush = 1'b1;
               eod_nx    = 1'b1;
            end else begin
               dec_push = 1'b1;
            end
         end
         if (dec_push) begin
            if (store_full) ovf_nx = 1'b1;
            else            len_nx = len_ff + LEN_W'(1);
         end
         // A flushed field is handed to the emission pointers and cleared.
         if (dec_flush) begin
            mode_nx = MODE_START;
            pend_nx = 1'b0;
            len_nx  = '0;
            ovf_nx  = 1'b0;
         end
      end
   end

   // Parser register updates on an accepted transfer.
   always_comb begin
      mode_in  = cmd.accept ? mode_nx : mode_ff;
      pend_in  = cmd.accept ? pend_nx : pend_ff;
      len_in   = cmd.accept ? len_nx  : len_ff;
      ovf_in   = cmd.accept ? ovf_nx  : ovf_ff;
      has_in   = cmd.accept ? has_nx  : has_ff;
      eod_in   = cmd.accept ? eod_nx  : eod_ff;
      lone_in  = cmd.accept ? lone_nx : lone_ff;
      delim_in = csr_valid ? csr_data : delim_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         mode_ff  <= MODE_START;
         pend_ff  <= 1'b0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         has_ff   <= 1'b0;
         eod_ff   <= 1'b0;
         lone_ff  <= 1'b0;
      end else begin
         delim_ff <= delim_in;
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         has_ff   <= has_in;
         eod_ff   <= eod_in;
         lone_ff  <= lone_in;
      end
   end

   // Field store: one write port for parsed bytes, one registered read port.
   assign hi_m1   = hi_ff - LEN_W'(1);
   assign rd_addr = (cmd.rd_sel == RD_HI) ? hi_m1[ADDR_W-1:0] : lo_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept && dec_push && !store_full) begin
         field_store[len_ff[ADDR_W-1:0]] <= req_tdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= field_store[rd_addr];
      end
   end

   // Trim pointers and per-field flags.
   assign span     = hi_ff - lo_ff;
   assign lo_p1    = lo_ff + LEN_W'(1);
   assign strip_ok = (span >= LEN_W'(2)) && fq_ff && lq_ff;

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      trunc_in = trunc_ff;
      rlast_in = rlast_ff;
      fq_in    = fq_ff;
      lq_in    = lq_ff;
      if (cmd.accept) begin
         lo_in    = '0;
         hi_in    = len_ff;
         trunc_in = dec_flush && ovf_ff;
         rlast_in = req_tlast;
      end
      if (cmd.lo_inc) lo_in = lo_p1;
      if (cmd.hi_dec) hi_in = hi_m1;
      if (cmd.strip && strip_ok) begin
         lo_in = lo_p1;
         hi_in = hi_m1;
      end
      if (cmd.set_fq) fq_in = (rd_data_ff == QUOTE_CHAR);
      if (cmd.set_lq) lq_in = (rd_data_ff == QUOTE_CHAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      trunc_ff <= trunc_in;
      rlast_ff <= rlast_in;
      fq_ff    <= fq_in;
      lq_ff    <= lq_in;
   end

   // Result register: holds one result until its transfer completes.
   assign out_valid_in = (cmd.load_byte || cmd.load_empty) ? 1'b1 :
                         (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.load_byte) begin
         out_byte_ff  <= rd_data_ff;
         out_flast_ff <= (lo_p1 == hi_ff);
         out_empty_ff <= 1'b0;
         out_rlast_ff <= rlast_ff && (lo_p1 == hi_ff);
         out_trunc_ff <= trunc_ff;
      end else if (cmd.load_empty) begin
         out_byte_ff  <= 8'h00;
         out_flast_ff <= 1'b1;
         out_empty_ff <= 1'b1;
         out_rlast_ff <= cmd.empty_lone ? 1'b0 : rlast_ff;
         out_trunc_ff <= cmd.empty_lone ? 1'b0 : trunc_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_flast_ff;
   assign rsp_tuser  = {out_trunc_ff, out_rlast_ff, out_empty_ff};

   // Status to the controller.
   always_comb begin
      status.emit_lone   = dec_lone;
      status.do_flush    = dec_flush;
      status.eor_empty   = dec_eor_empty;
      status.lo_lt_hi    = (lo_ff < hi_ff);
      status.rd_is_ws    = is_space(rd_data_ff);
      status.emit_last   = (lo_p1 == hi_ff);
      status.strip_empty = (span == LEN_W'(2)) && fq_ff && lq_ff;
      status.out_free    = !out_valid_ff || rsp_tready;
   end

   // The trim window never inverts.
   assert property (@(posedge clock) disable iff (reset) lo_ff <= hi_ff)
      else $error("trim window inverted");

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) len_ff <= LEN_W'(FIELD_BYTES))
      else $error("field length beyond store depth");

   // Bytes are only dropped once the store is full.
   assert property (@(posedge clock) disable iff (reset) ovf_ff |-> store_full)
      else $error("overflow flagged with room left");

   // An empty field is a single result carrying a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |-> (out_flast_ff && (out_byte_ff == 8'h00)))
      else $error("malformed empty field result");

   // The last result of a record also closes its field.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rlast_ff) |-> out_flast_ff)
      else $error("record end without field end");

endmodule
